[rtl/nfcp_pkg.sv]
// Package with the types, codes and constants of the NOR flash command planner.
`timescale 1ns / 1ps

package nfcp_pkg;

  // Field widths of the request and result words.
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned ADDR_W   = 24;
  localparam int unsigned LEN_W    = 25;
  localparam int unsigned SECTOR_W = 12;
  localparam int unsigned OPCODE_W = 8;
  localparam int unsigned STATUS_W = 2;

  // Internal position width: start address plus a 25-bit length plus a block step.
  localparam int unsigned POS_W = ADDR_W + 3;

  // Geometry defaults.
  localparam int unsigned DEF_PAGE_BYTES   = 256;
  localparam int unsigned DEF_SECTOR_BYTES = 4096;
  localparam int unsigned DEF_BLOCK_BYTES  = 65536;

  // Flash opcodes.
  localparam logic [OPCODE_W-1:0] OP_READ         = 8'h03;
  localparam logic [OPCODE_W-1:0] OP_PROGRAM      = 8'h02;
  localparam logic [OPCODE_W-1:0] OP_BLOCK_ERASE  = 8'hD8;
  localparam logic [OPCODE_W-1:0] OP_SECTOR_ERASE = 8'h20;
  localparam logic [OPCODE_W-1:0] OP_NONE         = 8'h00;

  typedef enum logic [ACTION_W-1:0] {
    ACT_READ         = 3'd0,
    ACT_WRITE        = 3'd1,
    ACT_ERASE_RANGE  = 3'd2,
    ACT_ERASE_SECTOR = 3'd3,
    ACT_NEXT         = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    KIND_IDLE  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_ERASE = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_UNALIGNED = 2'd1,
    ST_NEXT_IDLE = 2'd2
  } status_e;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [ADDR_W-1:0]   start_address;
    logic [LEN_W-1:0]    length;
    logic [SECTOR_W-1:0] sector_number;
  } item_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] command_opcode;
    logic [ADDR_W-1:0]   command_address;
    logic [LEN_W-1:0]    data_length;
    logic                has_command;
    logic                done_res;
    status_e             status;
  } result_t;

  typedef struct packed {
    kind_e            kind;
    logic [POS_W-1:0] cur;
    logic [POS_W-1:0] fin;
  } plan_state_t;

endpackage

[rtl/nfcp_req_if.sv]
// Channel interfaces for request words and result words of the planner.
`timescale 1ns / 1ps

interface nfcp_req_if import nfcp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [ADDR_W-1:0]   start_address;
  logic [LEN_W-1:0]    length;
  logic [SECTOR_W-1:0] sector_number;

  modport source (output valid, action, start_address, length, sector_number, input ready);
  modport sink   (input valid, action, start_address, length, sector_number, output ready);
endinterface

interface nfcp_res_if import nfcp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] command_opcode;
  logic [ADDR_W-1:0]   command_address;
  logic [LEN_W-1:0]    data_length;
  logic                has_command;
  logic                done_res;
  logic [STATUS_W-1:0] status;

  modport source (output valid, command_opcode, command_address, data_length, has_command,
                  done_res, status, input ready);
  modport sink   (input valid, command_opcode, command_address, data_length, has_command,
                  done_res, status, output ready);
endinterface

[rtl/nfcp_plan.sv]
// Combinational planning step: one request word and the plan state give one result.
`timescale 1ns / 1ps

module nfcp_plan import nfcp_pkg::*; #(
  parameter int unsigned PAGE_BYTES   = DEF_PAGE_BYTES,
  parameter int unsigned SECTOR_BYTES = DEF_SECTOR_BYTES,
  parameter int unsigned BLOCK_BYTES  = DEF_BLOCK_BYTES
) (
  input  item_t       item_i,
  input  plan_state_t state_i,
  output result_t     res_o,
  output plan_state_t state_o
);

  localparam int unsigned PAGE_LOG   = $clog2(PAGE_BYTES);
  localparam int unsigned SECTOR_LOG = $clog2(SECTOR_BYTES);
  localparam int unsigned BLOCK_LOG  = $clog2(BLOCK_BYTES);

  logic [POS_W-1:0] addr_w, len_w, last_w, erase_fin_w;
  logic             len_zero, addr_unaligned;
  logic             is_write_start, is_erase_start;

  logic [POS_W-1:0] wr_cur, wr_fin, wr_room, wr_remain, wr_chunk, wr_next;
  logic             wr_done;
  logic [POS_W-1:0] er_cur, er_fin, er_span, er_next;
  logic             er_block, er_done;

  assign addr_w         = POS_W'(item_i.start_address);
  assign len_w          = POS_W'(item_i.length);
  assign len_zero       = (item_i.length == '0);
  assign addr_unaligned = (item_i.start_address[SECTOR_LOG-1:0] != '0);
  assign last_w         = addr_w + len_w - POS_W'(1);
  assign erase_fin_w    = {last_w[POS_W-1:SECTOR_LOG], {SECTOR_LOG{1'b0}}};

  assign is_write_start = (item_i.action == ACT_WRITE);
  assign is_erase_start = (item_i.action == ACT_ERASE_RANGE);

  // Page program step: stop at the page end or at the end of the write.
  assign wr_cur    = is_write_start ? addr_w : state_i.cur;
  assign wr_fin    = is_write_start ? (addr_w + len_w) : state_i.fin;
  assign wr_room   = POS_W'(PAGE_BYTES) - POS_W'(wr_cur[PAGE_LOG-1:0]);
  assign wr_remain = wr_fin - wr_cur;
  assign wr_chunk  = (wr_room < wr_remain) ? wr_room : wr_remain;
  assign wr_next   = wr_cur + wr_chunk;
  assign wr_done   = (wr_next >= wr_fin);

  // Erase step: a block erase when aligned and a sector lies past the block.
  assign er_cur   = is_erase_start ? addr_w : state_i.cur;
  assign er_fin   = is_erase_start ? erase_fin_w : state_i.fin;
  assign er_span  = er_fin - er_cur;
  assign er_block = (er_cur[BLOCK_LOG-1:0] == '0) && (er_span >= POS_W'(BLOCK_BYTES));
  assign er_next  = er_cur + (er_block ? POS_W'(BLOCK_BYTES) : POS_W'(SECTOR_BYTES));
  assign er_done  = (er_next > er_fin);

  always_comb begin
    res_o.command_opcode  = OP_NONE;
    res_o.command_address = '0;
    res_o.data_length     = '0;
    res_o.has_command     = 1'b0;
    res_o.done_res        = 1'b1;
    res_o.status          = ST_OK;
    state_o               = state_i;

    case (item_i.action)
      ACT_READ: begin
        state_o.kind          = KIND_IDLE;
        res_o.command_opcode  = OP_READ;
        res_o.command_address = item_i.start_address;
        res_o.data_length     = item_i.length;
        res_o.has_command     = 1'b1;
      end
      ACT_WRITE: begin
        state_o.kind = KIND_IDLE;
        if (!len_zero) begin
          state_o.kind          = wr_done ? KIND_IDLE : KIND_WRITE;
          state_o.cur           = wr_next;
          state_o.fin           = wr_fin;
          res_o.command_opcode  = OP_PROGRAM;
          res_o.command_address = ADDR_W'(wr_cur);
          res_o.data_length     = LEN_W'(wr_chunk);
          res_o.has_command     = 1'b1;
          res_o.done_res        = wr_done;
        end
      end
      ACT_ERASE_RANGE: begin
        state_o.kind = KIND_IDLE;
        if (addr_unaligned) begin
          res_o.status = ST_UNALIGNED;
        end else if (!len_zero) begin
          state_o.kind          = er_done ? KIND_IDLE : KIND_ERASE;
          state_o.cur           = er_next;
          state_o.fin           = er_fin;
          res_o.command_opcode  = er_block ? OP_BLOCK_ERASE : OP_SECTOR_ERASE;
          res_o.command_address = ADDR_W'(er_cur);
          res_o.has_command     = 1'b1;
          res_o.done_res        = er_done;
        end
      end
      ACT_ERASE_SECTOR: begin
        state_o.kind          = KIND_IDLE;
        res_o.command_opcode  = OP_SECTOR_ERASE;
        res_o.command_address = ADDR_W'({item_i.sector_number, {SECTOR_LOG{1'b0}}});
        res_o.has_command     = 1'b1;
      end
      ACT_NEXT: begin
        case (state_i.kind)
          KIND_WRITE: begin
            state_o.kind          = wr_done ? KIND_IDLE : KIND_WRITE;
            state_o.cur           = wr_next;
            res_o.command_opcode  = OP_PROGRAM;
            res_o.command_address = ADDR_W'(wr_cur);
            res_o.data_length     = LEN_W'(wr_chunk);
            res_o.has_command     = 1'b1;
            res_o.done_res        = wr_done;
          end
          KIND_ERASE: begin
            state_o.kind          = er_done ? KIND_IDLE : KIND_ERASE;
            state_o.cur           = er_next;
            res_o.command_opcode  = er_block ? OP_BLOCK_ERASE : OP_SECTOR_ERASE;
            res_o.command_address = ADDR_W'(er_cur);
            res_o.has_command     = 1'b1;
            res_o.done_res        = er_done;
          end
          default: begin
            res_o.status = ST_NEXT_IDLE;
          end
        endcase
      end
      default: begin
        res_o.done_res = (state_i.kind == KIND_IDLE);
      end
    endcase
  end

endmodule

[rtl/nor_flash_command_planner.sv]
// Top level of the NOR flash command planner: input stage, plan state and result stage.
`timescale 1ns / 1ps

// The planner turns flash operations into single serial NOR commands.
// Request words arrive on req_i (valid/ready): an action code, a start
// address, a length and a sector number. Each request word gives exactly one
// result word on res_o: opcode, address, data length, a has-command flag, a
// done flag and a status code. A write or a range erase is started by its
// request word and continued by one "next" word per further command.
// A request word accepted on req_i is held in the input register, planned
// there against the stored plan state, and moves into the result register
// once that register is empty or being emptied; its result word is then
// valid on res_o. One word is accepted in every cycle while results are
// taken.
// If the receiver stalls, the result register holds its word and the input
// register still takes one more request; after that req_i.ready drops until
// res_o.ready returns. The plan state advances only when a word moves from
// the input register into the result register, so order is kept.
// Reset clears both valid flags and puts the plan state to idle at address
// zero; the block takes requests as soon as reset is released.
module nor_flash_command_planner import nfcp_pkg::*; #(
  parameter int unsigned PAGE_BYTES   = DEF_PAGE_BYTES,
  parameter int unsigned SECTOR_BYTES = DEF_SECTOR_BYTES,
  parameter int unsigned BLOCK_BYTES  = DEF_BLOCK_BYTES
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  nfcp_req_if.sink         req_i,
  nfcp_res_if.source       res_o
);

  item_t       item_q;
  logic        item_valid_q;
  result_t     res_q, res_d;
  logic        res_valid_q;
  plan_state_t state_q, state_d;
  logic        advance;
  logic        req_take;

  // A word moves on when the result register is empty or being emptied.
  assign advance  = item_valid_q && (!res_valid_q || res_o.ready);
  assign req_i.ready = !item_valid_q || advance;
  assign req_take = req_i.valid && req_i.ready;

  nfcp_plan #(
    .PAGE_BYTES  (PAGE_BYTES),
    .SECTOR_BYTES(SECTOR_BYTES),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_plan (
    .item_i (item_q),
    .state_i(state_q),
    .res_o  (res_d),
    .state_o(state_d)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      item_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_take) begin
      item_q.action        <= req_i.action;
      item_q.start_address <= req_i.start_address;
      item_q.length        <= req_i.length;
      item_q.sector_number <= req_i.sector_number;
    end
  end

  // Plan state follows each word that leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.kind <= KIND_IDLE;
      state_q.cur  <= '0;
      state_q.fin  <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid           = res_valid_q;
  assign res_o.command_opcode  = res_q.command_opcode;
  assign res_o.command_address = res_q.command_address;
  assign res_o.data_length     = res_q.data_length;
  assign res_o.has_command     = res_q.has_command;
  assign res_o.done_res        = res_q.done_res;
  assign res_o.status          = res_q.status;

  // A result without a command carries zero opcode, address and length.
  a_empty_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_q.has_command |->
      res_q.command_opcode == OP_NONE && res_q.command_address == '0 &&
      res_q.data_length == '0)
    else $error("result without a command has nonzero payload");

  // A pending write always has bytes left; a pending erase has a sector left.
  a_pending_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.kind == KIND_WRITE |-> state_q.cur < state_q.fin) and
    (state_q.kind == KIND_ERASE |-> state_q.cur <= state_q.fin))
    else $error("pending plan state past its end");

  // An error status ends the operation and issues nothing.
  a_status_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.status != ST_OK |-> res_q.done_res && !res_q.has_command)
    else $error("error result with a command or without done");

  // A word held back in the input register keeps its contents.
  a_input_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_q && !advance |=> item_valid_q && $stable(item_q))
    else $error("stalled request word lost or changed");

endmodule

[sim/tb_nor_flash_command_planner.sv]
// Self-checking testbench of the NOR flash command planner: directed table, random sequences.
`timescale 1ns / 1ps

module tb_nor_flash_command_planner;
  import nfcp_pkg::*;

  // Total request words of the run, directed rows included.
  localparam int unsigned TOTAL_WORDS = 1350;
  // The last words of the run go through with no idling on either side.
  localparam int unsigned QUIET_WORDS = 150;

  localparam logic [31:0] PAGE_SZ   = DEF_PAGE_BYTES;
  localparam logic [31:0] SECTOR_SZ = DEF_SECTOR_BYTES;
  localparam logic [31:0] BLOCK_SZ  = DEF_BLOCK_BYTES;
  localparam logic [31:0] FULL_LEN  = 32'h0100_0000;

  // Action codes that the planner does not define.
  localparam logic [ACTION_W-1:0] ACT_RSVD_LO = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_RSVD_HI = 3'd7;

  typedef struct {
    item_t   w;
    bit      fixed;
    result_t res;
  } dir_row_t;

  logic clk;
  logic rst_n;

  nfcp_req_if req ();
  nfcp_res_if res ();

  nor_flash_command_planner dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req),
    .res_o (res)
  );

  // Shadow of the planner state, advanced once per accepted request word.
  kind_e       plan_kind;
  logic [31:0] plan_cur;
  logic [31:0] plan_fin;

  result_t     cmd_expect_q[$];
  dir_row_t    dir_rows[$];

  // A directed row may carry its own expected result along with the word.
  logic        word_fixed;
  result_t     word_fixed_res;

  bit          quiet;
  bit          sender_busy;
  int unsigned words_sent;
  int unsigned results_checked;
  int unsigned commands_seen;
  int unsigned errors;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic result_t mk_result(input logic [OPCODE_W-1:0] op,
                                        input logic [ADDR_W-1:0] a, input logic [LEN_W-1:0] l,
                                        input logic has, input logic done, input status_e st);
    result_t r;
    r.command_opcode  = op;
    r.command_address = a;
    r.data_length     = l;
    r.has_command     = has;
    r.done_res        = done;
    r.status          = st;
    return r;
  endfunction

  function automatic item_t mk_item(input logic [ACTION_W-1:0] act, input logic [31:0] a,
                                    input logic [31:0] l, input logic [31:0] sec);
    item_t w;
    w.action        = act;
    w.start_address = a[ADDR_W-1:0];
    w.length        = l[LEN_W-1:0];
    w.sector_number = sec[SECTOR_W-1:0];
    return w;
  endfunction

  // One page program command: up to the end of the current page or of the write.
  function automatic result_t program_chunk();
    logic [31:0] c;
    logic [31:0] pg_end;
    logic [31:0] chunk;
    c      = plan_cur;
    pg_end = c - (c % PAGE_SZ) + PAGE_SZ;
    chunk  = plan_fin - c;
    if (pg_end - c < chunk) begin
      chunk = pg_end - c;
    end
    plan_cur = c + chunk;
    if (plan_cur >= plan_fin) begin
      plan_kind = KIND_IDLE;
    end
    return mk_result(OP_PROGRAM, c[ADDR_W-1:0], chunk[LEN_W-1:0], 1'b1,
                     plan_kind == KIND_IDLE, ST_OK);
  endfunction

  // One erase command: a block where aligned with a sector left past it, else a sector.
  function automatic result_t erase_chunk();
    logic [31:0]         c;
    logic [OPCODE_W-1:0] op;
    c = plan_cur;
    if ((c % BLOCK_SZ) == 0 && plan_fin - c >= BLOCK_SZ) begin
      op       = OP_BLOCK_ERASE;
      plan_cur = c + BLOCK_SZ;
    end else begin
      op       = OP_SECTOR_ERASE;
      plan_cur = c + SECTOR_SZ;
    end
    if (plan_cur > plan_fin) begin
      plan_kind = KIND_IDLE;
    end
    return mk_result(op, c[ADDR_W-1:0], '0, 1'b1, plan_kind == KIND_IDLE, ST_OK);
  endfunction

  // Works out the command that one request word yields and advances the shadow state.
  function automatic result_t plan_command(input item_t w);
    logic [31:0] a;
    logic [31:0] l;
    logic [31:0] last;
    result_t     none_r;
    a      = {8'd0, w.start_address};
    l      = {7'd0, w.length};
    none_r = mk_result(OP_NONE, '0, '0, 1'b0, 1'b1, ST_OK);
    case (w.action)
      ACT_READ: begin
        plan_kind = KIND_IDLE;
        return mk_result(OP_READ, a[ADDR_W-1:0], l[LEN_W-1:0], 1'b1, 1'b1, ST_OK);
      end
      ACT_WRITE: begin
        plan_kind = KIND_IDLE;
        if (l == 0) begin
          return none_r;
        end
        plan_kind = KIND_WRITE;
        plan_cur  = a;
        plan_fin  = a + l;
        return program_chunk();
      end
      ACT_ERASE_RANGE: begin
        plan_kind = KIND_IDLE;
        if ((a % SECTOR_SZ) != 0) begin
          none_r.status = ST_UNALIGNED;
          return none_r;
        end
        // An empty range erases nothing.
        if (l == 0) begin
          return none_r;
        end
        last      = a + l - 1;
        plan_kind = KIND_ERASE;
        plan_cur  = a;
        plan_fin  = last - (last % SECTOR_SZ);
        return erase_chunk();
      end
      ACT_ERASE_SECTOR: begin
        plan_kind = KIND_IDLE;
        return mk_result(OP_SECTOR_ERASE, {w.sector_number, 12'h000}, '0, 1'b1, 1'b1, ST_OK);
      end
      ACT_NEXT: begin
        if (plan_kind == KIND_WRITE) begin
          return program_chunk();
        end
        if (plan_kind == KIND_ERASE) begin
          return erase_chunk();
        end
        none_r.status = ST_NEXT_IDLE;
        return none_r;
      end
      default: begin
        // Undefined actions leave the plan alone and only report whether it is idle.
        none_r.done_res = (plan_kind == KIND_IDLE);
        return none_r;
      end
    endcase
  endfunction

  task automatic add_row(input logic [ACTION_W-1:0] act, input logic [31:0] a,
                         input logic [31:0] l, input logic [31:0] sec, input bit fixed,
                         input result_t r);
    dir_row_t row;
    row.w     = mk_item(act, a, l, sec);
    row.fixed = fixed;
    row.res   = r;
    dir_rows.push_back(row);
  endtask

  task automatic lower_valid();
    if (sender_busy) begin
      req.valid <= 1'b0;
      sender_busy = 1'b0;
    end
  endtask

  // Called at a rising edge. Presents one word, returns at the edge that accepts it, and
  // now and then leaves a gap of idle cycles behind it.
  task automatic send_word(input item_t w, input bit fixed, input result_t r);
    req.valid         <= 1'b1;
    req.action        <= w.action;
    req.start_address <= w.start_address;
    req.length        <= w.length;
    req.sector_number <= w.sector_number;
    word_fixed        <= fixed;
    word_fixed_res    <= r;
    sender_busy = 1'b1;
    do @(negedge clk); while (!req.ready);
    @(posedge clk);
    words_sent++;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      lower_valid();
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic check_result(input result_t e);
    if (res.command_opcode !== e.command_opcode) begin
      $display("%0t: opcode mismatch, expected %h, got %h", $time, e.command_opcode,
               res.command_opcode);
      errors++;
    end
    if (res.command_address !== e.command_address) begin
      $display("%0t: address mismatch, expected %h, got %h", $time, e.command_address,
               res.command_address);
      errors++;
    end
    if (res.data_length !== e.data_length) begin
      $display("%0t: data length mismatch, expected %h, got %h", $time, e.data_length,
               res.data_length);
      errors++;
    end
    if (res.has_command !== e.has_command) begin
      $display("%0t: has_command mismatch, expected %b, got %b", $time, e.has_command,
               res.has_command);
      errors++;
    end
    if (res.done_res !== e.done_res) begin
      $display("%0t: done mismatch, expected %b, got %b", $time, e.done_res, res.done_res);
      errors++;
    end
    if (res.status !== e.status) begin
      $display("%0t: status mismatch, expected %0d, got %0d", $time, e.status, res.status);
      errors++;
    end
  endtask

  // Both channels are sampled at the falling edge: nothing changes between there and the
  // next rising edge, so a handshake seen here is the one that completes at that edge.
  always @(negedge clk) begin
    item_t   w;
    result_t pred;
    if (rst_n) begin
      if (res.valid && res.ready) begin
        if (cmd_expect_q.size() == 0) begin
          $display("%0t: result word with no request waiting, got opcode %h address %h",
                   $time, res.command_opcode, res.command_address);
          errors++;
        end else begin
          check_result(cmd_expect_q.pop_front());
          results_checked++;
          if (res.has_command) begin
            commands_seen++;
          end
        end
      end
      if (req.valid && req.ready) begin
        w = mk_item(req.action, {8'd0, req.start_address}, {7'd0, req.length},
                    {20'd0, req.sector_number});
        // The shadow state advances on every word, even where a row gives its own result.
        pred = plan_command(w);
        cmd_expect_q.push_back(word_fixed ? word_fixed_res : pred);
      end
    end
  end

  // The receiver alternates bursts of stalls and of ready cycles until the quiet tail.
  initial begin
    res.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (quiet) begin
        res.ready <= 1'b1;
        @(posedge clk);
      end else begin
        res.ready <= ($urandom_range(0, 2) != 0);
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    item_t       w;
    result_t     none_r;
    int unsigned pick;
    int unsigned n_next;
    logic [31:0] a;
    logic [31:0] l;
    logic [31:0] last;
    logic [31:0] fin;
    logic [31:0] c;

    plan_kind       = KIND_IDLE;
    plan_cur        = '0;
    plan_fin        = '0;
    quiet           = 1'b0;
    sender_busy     = 1'b0;
    words_sent      = 0;
    results_checked = 0;
    commands_seen   = 0;
    errors          = 0;
    none_r          = mk_result(OP_NONE, '0, '0, 1'b0, 1'b1, ST_OK);

    rst_n             <= 1'b0;
    req.valid         <= 1'b0;
    req.action        <= ACT_READ;
    req.start_address <= '0;
    req.length        <= '0;
    req.sector_number <= '0;
    word_fixed        <= 1'b0;
    word_fixed_res    <= '0;

    // Directed table. Rows marked fixed carry a result that can be read off directly.
    add_row(ACT_NEXT, 0, 0, 0, 1, mk_result(OP_NONE, '0, '0, 1'b0, 1'b1, ST_NEXT_IDLE));
    add_row(ACT_RSVD_LO, 32'hFFFFFF, FULL_LEN, 32'hFFF, 1, none_r);
    add_row(ACT_READ, 0, 0, 0, 1, mk_result(OP_READ, '0, '0, 1'b1, 1'b1, ST_OK));
    add_row(ACT_READ, 32'hFFFFFF, FULL_LEN, 32'hFFF, 1,
            mk_result(OP_READ, 24'hFFFFFF, 25'h1000000, 1'b1, 1'b1, ST_OK));
    add_row(ACT_WRITE, 32'h123456, 0, 0, 1, none_r);
    // A write that crosses one page boundary, then a next once it has finished.
    add_row(ACT_WRITE, 32'h0000F0, 32'h20, 0, 0, none_r);
    add_row(ACT_NEXT, 0, 0, 0, 0, none_r);
    add_row(ACT_NEXT, 0, 0, 0, 1, mk_result(OP_NONE, '0, '0, 1'b0, 1'b1, ST_NEXT_IDLE));
    // A write that runs past the top of the address space and wraps to zero.
    add_row(ACT_WRITE, 32'hFFFFF0, 32'h40, 0, 0, none_r);
    add_row(ACT_NEXT, 0, 0, 0, 0, none_r);
    // An undefined action in the middle of a write does not disturb it.
    add_row(ACT_WRITE, 32'h000100, 32'h1FF, 0, 0, none_r);
    add_row(ACT_RSVD_HI, 0, 0, 0, 0, none_r);
    add_row(ACT_NEXT, 0, 0, 0, 0, none_r);
    add_row(ACT_ERASE_RANGE, 32'h000801, 32'h1000, 0, 1,
            mk_result(OP_NONE, '0, '0, 1'b0, 1'b1, ST_UNALIGNED));
    add_row(ACT_ERASE_RANGE, 32'hFFF000, 0, 0, 1, none_r);
    add_row(ACT_ERASE_RANGE, 0, 32'h20000, 0, 0, none_r);
    add_row(ACT_NEXT, 0, 0, 0, 0, none_r);
    // The largest erase, wrapping past the top, is cut short by a new start.
    add_row(ACT_ERASE_RANGE, 32'hFF0000, FULL_LEN, 0, 0, none_r);
    add_row(ACT_NEXT, 0, 0, 0, 0, none_r);
    add_row(ACT_NEXT, 0, 0, 0, 0, none_r);
    add_row(ACT_ERASE_SECTOR, 32'hFFFFFF, FULL_LEN, 0, 1,
            mk_result(OP_SECTOR_ERASE, '0, '0, 1'b1, 1'b1, ST_OK));
    add_row(ACT_NEXT, 0, 0, 0, 1, mk_result(OP_NONE, '0, '0, 1'b0, 1'b1, ST_NEXT_IDLE));
    add_row(ACT_ERASE_SECTOR, 0, 0, 32'hFFF, 1,
            mk_result(OP_SECTOR_ERASE, 24'hFFF000, '0, 1'b1, 1'b1, ST_OK));
    add_row(ACT_ERASE_RANGE, 32'h00F000, 32'h11000, 0, 0, none_r);
    add_row(ACT_NEXT, 0, 0, 0, 0, none_r);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].w, dir_rows[i].fixed, dir_rows[i].res);
    end

    // Hold the sender off until every outstanding result has drained.
    lower_valid();
    while (cmd_expect_q.size() != 0) @(posedge clk);
    @(posedge clk);

    // Random part: mostly complete write and erase sequences, with noise mixed in.
    while (words_sent < TOTAL_WORDS) begin
      quiet  = (words_sent >= TOTAL_WORDS - QUIET_WORDS);
      pick   = $urandom_range(0, 99);
      n_next = 0;
      if (pick < 30) begin
        a = $urandom() & 32'hFFFFFF;
        if ($urandom_range(0, 9) == 0) begin
          a[23:8] = 16'hFFFF;
        end
        case ($urandom_range(0, 9))
          0:       l = 0;
          1:       l = $urandom_range(1024, 4096);
          default: l = $urandom_range(1, 600);
        endcase
        send_word(mk_item(ACT_WRITE, a, l, $urandom()), 0, none_r);
        if (l != 0) begin
          n_next = ((a % PAGE_SZ) + l + PAGE_SZ - 1) / PAGE_SZ - 1;
        end
      end else if (pick < 55) begin
        a = {8'd0, 12'($urandom_range(0, 4095)), 12'h000};
        if ($urandom_range(0, 3) == 0) begin
          a[15:12] = 4'h0;
        end
        if ($urandom_range(0, 9) == 0) begin
          a[11:0] = 12'($urandom_range(1, 4095));
        end
        case ($urandom_range(0, 9))
          0:       l = 0;
          1:       l = $urandom_range(1, 32'h40000);
          default: l = $urandom_range(1, 32'h6000);
        endcase
        send_word(mk_item(ACT_ERASE_RANGE, a, l, $urandom()), 0, none_r);
        // Count the erase commands so the sequence of nexts ends where the plan does.
        if ((a % SECTOR_SZ) == 0 && l != 0) begin
          last = a + l - 1;
          fin  = last - (last % SECTOR_SZ);
          c    = a;
          do begin
            if ((c % BLOCK_SZ) == 0 && fin - c >= BLOCK_SZ) begin
              c = c + BLOCK_SZ;
            end else begin
              c = c + SECTOR_SZ;
            end
            n_next++;
          end while (c <= fin);
          n_next--;
        end
      end else if (pick < 70) begin
        l = ($urandom_range(0, 19) == 0) ? FULL_LEN : $urandom_range(0, FULL_LEN);
        send_word(mk_item(ACT_READ, $urandom(), l, $urandom()), 0, none_r);
      end else if (pick < 82) begin
        send_word(mk_item(ACT_ERASE_SECTOR, $urandom(), $urandom_range(0, FULL_LEN),
                          $urandom()), 0, none_r);
      end else if (pick < 92) begin
        send_word(mk_item(ACT_NEXT, $urandom(), $urandom_range(0, FULL_LEN), $urandom()),
                  0, none_r);
      end else begin
        send_word(mk_item(3'($urandom_range(ACT_RSVD_LO, ACT_RSVD_HI)), $urandom(),
                          $urandom_range(0, FULL_LEN), $urandom()), 0, none_r);
      end
      // Now and then a sequence is broken off early or runs one next too far.
      if (n_next != 0 && $urandom_range(0, 7) == 0) begin
        n_next = $urandom_range(0, n_next);
      end else if ($urandom_range(0, 7) == 0) begin
        n_next++;
      end
      repeat (n_next) begin
        if ($urandom_range(0, 15) == 0) begin
          w = mk_item(3'($urandom_range(ACT_RSVD_LO, ACT_RSVD_HI)), $urandom(), 0, 0);
        end else begin
          w = mk_item(ACT_NEXT, $urandom(), $urandom_range(0, FULL_LEN), $urandom());
        end
        send_word(w, 0, none_r);
      end
    end

    lower_valid();
    while (cmd_expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d request words and checked %0d result words, %0d of them commands.",
             words_sent, results_checked, commands_seen);
    $display("Covered reads, split writes, block and sector erases, wraps and error cases.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[nor_flash_command_planner.f]
rtl/nfcp_pkg.sv
rtl/nfcp_req_if.sv
rtl/nfcp_plan.sv
rtl/nor_flash_command_planner.sv
sim/tb_nor_flash_command_planner.sv
